[rtl/tct_pkg.sv]
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and encoding constants for the Thumb-2 constant tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam int NUM_REGS  = 16;
  localparam int REG_IDX_W = 4;
  localparam int CFG_IDX_W = 1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE     = 1'd1;

  // encoding masks and patterns
  localparam logic [15:0] MOVN_MASK   = 16'hF800;
  localparam logic [15:0] MOVN_PAT    = 16'h2000;
  localparam logic [15:0] MOVI_MASK   = 16'hFBEF;
  localparam logic [15:0] MOVI_PAT    = 16'hF04F;
  localparam logic [15:0] MOV16_MASK  = 16'hFBF0;
  localparam logic [15:0] MOVW_PAT    = 16'hF240;
  localparam logic [15:0] MOVT_PAT    = 16'hF2C0;
  localparam logic [15:0] LDRN_MASK   = 16'hF800;
  localparam logic [15:0] LDRN_PAT    = 16'h4800;
  localparam logic [15:0] LDRW_MASK   = 16'hFF7F;
  localparam logic [15:0] LDRW_PAT    = 16'hF85F;
  localparam logic [15:0] ADD3_MASK   = 16'hFE00;
  localparam logic [15:0] ADD3_PAT    = 16'h1800;
  localparam logic [15:0] ADDHI_MASK  = 16'hFF00;
  localparam logic [15:0] ADDHI_PAT   = 16'h4400;
  localparam logic [15:0] ADDW_MASK   = 16'hFFE0;
  localparam logic [15:0] ADDW_PAT    = 16'hEB00;
  localparam logic [32:0] WORD_ALIGN  = {1'b1, 32'hFFFFFFFC};
  localparam logic [REG_IDX_W-1:0] PC_IDX = 4'd15;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOV,
    OP_LDR,
    OP_MOVT,
    OP_ADD
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 wide;
    logic [REG_IDX_W-1:0] rd;
    logic [31:0]          value;
    logic                 ldr_sub;
  } dec_t;

endpackage

[rtl/thumb2_constant_xref_tracker.sv]
// ----------------------------------------------------------------------------
// thumb2_constant_xref_tracker
// Tracks constants loaded into core registers by a Thumb-2 instruction
// stream and flags ADD Rd,PC results that equal the target address.
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_stall  | first_item, insn_offset, halfwords, literal
//   out_    | out       | out_valid / out_stall| found, wide, match_offset
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request accepted per cycle unless in_stall is high; stages are the input register, then
// decode, register file read-modify-write and compare into the result
// register. The register file update and the next request's read meet in
// the same single execute stage. Synchronous active-low reset clears the
// register file valid bits, config and pipe valids; no clearing pass.
// An out_stall holds the result register and backs up into in_stall once
// the input register is full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module thumb2_constant_xref_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_first_item,
  input  logic [31:0]                   in_insn_offset,
  input  logic [15:0]                   in_first_halfword,
  input  logic [15:0]                   in_second_halfword,
  input  logic [31:0]                   in_literal_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic                          out_wide,
  output logic [31:0]                   out_match_offset,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import tct_pkg::*;

  logic                 s1_vld_r;
  logic                 s1_first_r;
  logic [31:0]          s1_off_r;
  logic [15:0]          s1_h0_r;
  logic [15:0]          s1_h1_r;
  logic [31:0]          s1_lit_r;

  logic                 out_valid_r;
  logic                 out_found_r;
  logic                 out_wide_r;
  logic [31:0]          out_off_r;

  logic [31:0]          target_r;
  logic [31:0]          image_size_r;

  logic [31:0]          val_r [NUM_REGS];
  logic [NUM_REGS-1:0]  vld_r;
  logic [NUM_REGS-1:0]  vld_nxt;

  dec_t                 dec;
  logic                 out_adv;
  logic                 move;
  logic [31:0]          cur;
  logic [32:0]          pc_al;
  logic [33:0]          laddr;
  logic                 lit_ok;
  logic [31:0]          add_sum;
  logic                 wr_en;
  logic [31:0]          wr_data;
  logic                 found;

  tct_decode u_dec (
    .first_halfword  (s1_h0_r),
    .second_halfword (s1_h1_r),
    .dec             (dec)
  );

  assign out_adv   = ~out_valid_r | ~out_stall;
  assign move      = s1_vld_r & out_adv;
  assign in_stall  = s1_vld_r & ~out_adv;
  assign cfg_ready = 1'b1;

  assign cur = (s1_first_r || !vld_r[dec.rd]) ? 32'd0 : val_r[dec.rd];

  // literal address, no wrap
  assign pc_al  = ({1'b0, s1_off_r} + 33'd4) & WORD_ALIGN;
  assign laddr  = dec.ldr_sub ? ({1'b0, pc_al} - {2'b00, dec.value})
                              : ({1'b0, pc_al} + {2'b00, dec.value});
  assign lit_ok = ~laddr[33] && (({1'b0, laddr} + 35'd4) <= {3'b000, image_size_r});

  assign add_sum = cur + s1_off_r + 32'd4;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    found   = 1'b0;
    unique case (dec.op)
      OP_MOV: begin
        wr_en   = 1'b1;
        wr_data = dec.value;
      end
      OP_LDR: begin
        wr_en   = lit_ok;
        wr_data = s1_lit_r;
      end
      OP_MOVT: begin
        wr_en   = 1'b1;
        wr_data = {dec.value[15:0], cur[15:0]};
      end
      OP_ADD: begin
        wr_en   = 1'b1;
        wr_data = add_sum;
        found   = (add_sum == target_r);
      end
      OP_NONE: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      image_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_ADDRESS: target_r     <= cfg_data;
        CFG_IMAGE_SIZE:     image_size_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_first_r <= in_first_item;
      s1_off_r   <= in_insn_offset;
      s1_h0_r    <= in_first_halfword;
      s1_h1_r    <= in_second_halfword;
      s1_lit_r   <= in_literal_word;
    end
  end

  // register value file
  always_comb begin
    vld_nxt = s1_first_r ? '0 : vld_r;
    if (wr_en) begin
      vld_nxt[dec.rd] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (move) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move && wr_en) begin
      val_r[dec.rd] <= wr_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_found_r <= found;
      out_wide_r  <= dec.wide;
      out_off_r   <= s1_off_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_wide         = out_wide_r;
  assign out_match_offset = out_off_r;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_vld_r)
    else $error("accepted request not held in input register");

  a_move_result: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (out_valid_r && out_off_r == $past(s1_off_r)))
    else $error("result register did not take the request");

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (move && s1_first_r) |=> ($countones(vld_r) <= 1))
    else $error("register file not cleared on first item");

  a_found_add: assert property (@(posedge clk) disable iff (!rst_n)
    (move && found) |-> (dec.op == OP_ADD))
    else $error("found raised outside an add");

endmodule

[rtl/tct_decode.sv]
// ----------------------------------------------------------------------------
// tct_decode
// Instruction decode: classifies the instruction, picks the destination
// register and builds the immediate value or literal offset.
// ----------------------------------------------------------------------------
module tct_decode (
  input  logic [15:0]   first_halfword,
  input  logic [15:0]   second_halfword,
  output tct_pkg::dec_t dec
);
  import tct_pkg::*;

  function automatic logic [31:0] expand_imm(input logic [11:0] imm12);
    logic [7:0]  b;
    logic [63:0] dbl;
    logic [31:0] rv;
    b   = imm12[7:0];
    dbl = '0;
    rv  = '0;
    if (imm12[11:10] == 2'b00) begin
      unique case (imm12[9:8])
        2'd0: rv = {24'd0, b};
        2'd1: rv = {8'd0, b, 8'd0, b};
        2'd2: rv = {b, 8'd0, b, 8'd0};
        2'd3: rv = {b, b, b, b};
        default: rv = '0;
      endcase
    end else begin
      dbl = {24'd0, 1'b1, imm12[6:0], 24'd0, 1'b1, imm12[6:0]} >> imm12[11:7];
      rv  = dbl[31:0];
    end
    return rv;
  endfunction

  logic [15:0] h0;
  logic [15:0] h1;
  logic        h1_ok;
  logic [11:0] imm12;
  logic [15:0] imm16;

  assign h0    = first_halfword;
  assign h1    = second_halfword;
  assign h1_ok = ~h1[15];
  assign imm12 = {h0[10], h1[14:12], h1[7:0]};
  assign imm16 = {h0[3:0], imm12};

  always_comb begin
    dec         = '0;
    dec.op      = OP_NONE;
    dec.wide    = (h0[15:13] == 3'b111) && (h0[12:11] != 2'b00);
    dec.ldr_sub = 1'b0;
    priority if ((h0 & MOVN_MASK) == MOVN_PAT) begin
      dec.op    = OP_MOV;
      dec.rd    = {1'b0, h0[10:8]};
      dec.value = {24'd0, h0[7:0]};
    end else if ((h0 & MOVI_MASK) == MOVI_PAT && h1_ok) begin
      dec.op    = OP_MOV;
      dec.rd    = h1[11:8];
      dec.value = expand_imm(imm12);
    end else if ((h0 & MOV16_MASK) == MOVW_PAT && h1_ok) begin
      dec.op    = OP_MOV;
      dec.rd    = h1[11:8];
      dec.value = {16'd0, imm16};
    end else if ((h0 & LDRN_MASK) == LDRN_PAT) begin
      dec.op    = OP_LDR;
      dec.rd    = {1'b0, h0[10:8]};
      dec.value = {22'd0, h0[7:0], 2'b00};
    end else if ((h0 & LDRW_MASK) == LDRW_PAT) begin
      dec.op      = OP_LDR;
      dec.rd      = h1[15:12];
      dec.value   = {20'd0, h1[11:0]};
      dec.ldr_sub = ~h0[7];
    end else if ((h0 & MOV16_MASK) == MOVT_PAT && h1_ok) begin
      dec.op    = OP_MOVT;
      dec.rd    = h1[11:8];
      dec.value = {16'd0, imm16};
    end else if ((h0 & ADD3_MASK) == ADD3_PAT) begin
      // three-register form cannot name pc as rm
      dec.op = OP_NONE;
    end else if ((h0 & ADDHI_MASK) == ADDHI_PAT) begin
      if (h0[6:3] == PC_IDX) begin
        dec.op = OP_ADD;
        dec.rd = {h0[7], h0[2:0]};
      end
    end else if ((h0 & ADDW_MASK) == ADDW_PAT) begin
      if (h1[3:0] == PC_IDX && h0[3:0] == h1[11:8]) begin
        dec.op = OP_ADD;
        dec.rd = h1[11:8];
      end
    end else begin
      dec.op = OP_NONE;
    end
  end

endmodule
